>>> hw/rtl/scc_pkg.sv
// Shared types and constants for the segment contact classifier.
// Depends on nothing; used by segment_contact_classifier and the bench.
package scc_pkg;

  localparam int CoordW   = 16;
  localparam int NumCoord = 8;
  localparam int InDataW  = ((NumCoord * CoordW + 7) / 8) * 8;

  localparam int DiffW = CoordW + 1;
  localparam int ProdW = 2 * DiffW;
  localparam int SumW  = ProdW + 1;

  localparam int ContactW = 2;
  localparam int OutDataW = ((ContactW + 7) / 8) * 8;

  // Coordinate slots in the request, lowest tdata bits first
  localparam int IdxAx = 0;
  localparam int IdxAy = 1;
  localparam int IdxBx = 2;
  localparam int IdxBy = 3;
  localparam int IdxCx = 4;
  localparam int IdxCy = 5;
  localparam int IdxDx = 6;
  localparam int IdxDy = 7;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [SumW-1:0]   sum_t;

  typedef enum logic [ContactW-1:0] {
    CONTACT_NONE  = 2'd0,
    CONTACT_CROSS = 2'd1,
    CONTACT_TOUCH = 2'd2
  } contact_t;

  // All partial products of one request, held between the two stages
  typedef struct packed {
    prod_t cay_cdx;
    prod_t cax_cdy;
    prod_t cay_abx;
    prod_t cax_aby;
    prod_t abx_cdy;
    prod_t aby_cdx;
    prod_t abx_abx;
    prod_t aby_aby;
    prod_t acx_abx;
    prod_t acy_aby;
    prod_t adx_abx;
    prod_t ady_aby;
  } prod_set_t;

endpackage

>>> hw/rtl/segment_contact_classifier.sv
// Segment contact classifier top level: input register, product stage, decision stage.
// Depends on scc_pkg for widths, the product set type and the contact codes.
//
// Classifies two segments AB and CD given as signed CoordW-bit coordinates:
// no contact, crossing or overlap inside both segments, or touching at an
// endpoint. All arithmetic is exact integer math; the parameters r and s of
// the crossing point are tested against [0,1] by sign and magnitude compares
// on the cross-product numerators and the denominator, and collinear pairs are
// tested by projecting C and D onto AB against the squared length of AB.
// The block is a three-register pipeline (input, products, result) and takes
// one request every cycle unless a result is stuck. The whole pipeline holds
// only while a result waits on out_tready, so in_tready follows out_tready
// whenever the result register is full.
module segment_contact_classifier (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // ax, ay, bx, by, cx, cy, dx, dy, CoordW bits each, lowest bits first
  input  logic [scc_pkg::InDataW-1:0]  in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // contact in the low ContactW bits, zero padded
  output logic [scc_pkg::OutDataW-1:0] out_tdata
);

  // Single enable for every stage: advance unless a result is stuck
  logic advance;

  // Input register
  logic              in_valid_r;
  scc_pkg::coord_t   crd_r [scc_pkg::NumCoord];

  // Product stage
  scc_pkg::diff_t    abx, aby, cdx, cdy, cax, cay, acx, acy, adx, ady;
  scc_pkg::prod_set_t prod_nxt;
  scc_pkg::prod_set_t prod_r;
  logic              prod_valid_r;

  // Decision stage
  scc_pkg::sum_t     nr, ns, den, len, pc, pd;
  scc_pkg::sum_t     nr_n, ns_n, den_n;
  logic              den_zero;
  scc_pkg::contact_t contact_nxt;
  scc_pkg::contact_t contact_r;
  logic              out_valid_r;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance;

  // ---------------------------------------------------------------------------
  // Stage 1: capture the request
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (advance) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_tvalid) begin
      for (int i = 0; i < scc_pkg::NumCoord; i++) begin
        crd_r[i] <= in_tdata[i*scc_pkg::CoordW +: scc_pkg::CoordW];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: coordinate differences and all twelve products in parallel.
  // Differences are one bit wider than a coordinate so they never wrap.
  // ---------------------------------------------------------------------------
  always_comb begin
    abx = scc_pkg::diff_t'(crd_r[scc_pkg::IdxBx]) - scc_pkg::diff_t'(crd_r[scc_pkg::IdxAx]);
    aby = scc_pkg::diff_t'(crd_r[scc_pkg::IdxBy]) - scc_pkg::diff_t'(crd_r[scc_pkg::IdxAy]);
    cdx = scc_pkg::diff_t'(crd_r[scc_pkg::IdxDx]) - scc_pkg::diff_t'(crd_r[scc_pkg::IdxCx]);
    cdy = scc_pkg::diff_t'(crd_r[scc_pkg::IdxDy]) - scc_pkg::diff_t'(crd_r[scc_pkg::IdxCy]);
    cax = scc_pkg::diff_t'(crd_r[scc_pkg::IdxAx]) - scc_pkg::diff_t'(crd_r[scc_pkg::IdxCx]);
    cay = scc_pkg::diff_t'(crd_r[scc_pkg::IdxAy]) - scc_pkg::diff_t'(crd_r[scc_pkg::IdxCy]);
    acx = scc_pkg::diff_t'(crd_r[scc_pkg::IdxCx]) - scc_pkg::diff_t'(crd_r[scc_pkg::IdxAx]);
    acy = scc_pkg::diff_t'(crd_r[scc_pkg::IdxCy]) - scc_pkg::diff_t'(crd_r[scc_pkg::IdxAy]);
    adx = scc_pkg::diff_t'(crd_r[scc_pkg::IdxDx]) - scc_pkg::diff_t'(crd_r[scc_pkg::IdxAx]);
    ady = scc_pkg::diff_t'(crd_r[scc_pkg::IdxDy]) - scc_pkg::diff_t'(crd_r[scc_pkg::IdxAy]);

    // Products fit the doubled width exactly; operands are sign extended
    prod_nxt.cay_cdx = scc_pkg::prod_t'(cay) * scc_pkg::prod_t'(cdx);
    prod_nxt.cax_cdy = scc_pkg::prod_t'(cax) * scc_pkg::prod_t'(cdy);
    prod_nxt.cay_abx = scc_pkg::prod_t'(cay) * scc_pkg::prod_t'(abx);
    prod_nxt.cax_aby = scc_pkg::prod_t'(cax) * scc_pkg::prod_t'(aby);
    prod_nxt.abx_cdy = scc_pkg::prod_t'(abx) * scc_pkg::prod_t'(cdy);
    prod_nxt.aby_cdx = scc_pkg::prod_t'(aby) * scc_pkg::prod_t'(cdx);
    prod_nxt.abx_abx = scc_pkg::prod_t'(abx) * scc_pkg::prod_t'(abx);
    prod_nxt.aby_aby = scc_pkg::prod_t'(aby) * scc_pkg::prod_t'(aby);
    prod_nxt.acx_abx = scc_pkg::prod_t'(acx) * scc_pkg::prod_t'(abx);
    prod_nxt.acy_aby = scc_pkg::prod_t'(acy) * scc_pkg::prod_t'(aby);
    prod_nxt.adx_abx = scc_pkg::prod_t'(adx) * scc_pkg::prod_t'(abx);
    prod_nxt.ady_aby = scc_pkg::prod_t'(ady) * scc_pkg::prod_t'(aby);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
    end else if (advance) begin
      prod_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      prod_r <= prod_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: combine products, then classify.
  // Numerators nr, ns and denominator den; for the collinear case the
  // projections pc, pd of C and D onto AB and the squared length len.
  // ---------------------------------------------------------------------------
  always_comb begin
    nr  = scc_pkg::sum_t'(prod_r.cay_cdx) - scc_pkg::sum_t'(prod_r.cax_cdy);
    ns  = scc_pkg::sum_t'(prod_r.cay_abx) - scc_pkg::sum_t'(prod_r.cax_aby);
    den = scc_pkg::sum_t'(prod_r.abx_cdy) - scc_pkg::sum_t'(prod_r.aby_cdx);
    len = scc_pkg::sum_t'(prod_r.abx_abx) + scc_pkg::sum_t'(prod_r.aby_aby);
    pc  = scc_pkg::sum_t'(prod_r.acx_abx) + scc_pkg::sum_t'(prod_r.acy_aby);
    pd  = scc_pkg::sum_t'(prod_r.adx_abx) + scc_pkg::sum_t'(prod_r.ady_aby);

    den_zero = (den == '0);

    // Flip signs so the denominator is positive; no overflow at this width
    if (den[scc_pkg::SumW-1]) begin
      den_n = -den;
      nr_n  = -nr;
      ns_n  = -ns;
    end else begin
      den_n = den;
      nr_n  = nr;
      ns_n  = ns;
    end

    if (den_zero) begin
      if (nr != '0) begin
        // Parallel but not on one line
        contact_nxt = scc_pkg::CONTACT_NONE;
      end else if ((pc > len && pd > len) || (pc < 0 && pd < 0)) begin
        // Collinear, both ends of CD off the same side of AB
        contact_nxt = scc_pkg::CONTACT_NONE;
      end else if (pc == len || pd == len || pc == '0 || pd == '0) begin
        contact_nxt = scc_pkg::CONTACT_TOUCH;
      end else begin
        contact_nxt = scc_pkg::CONTACT_CROSS;
      end
    end else if (nr_n < 0 || nr_n > den_n || ns_n < 0 || ns_n > den_n) begin
      // r or s outside [0,1]
      contact_nxt = scc_pkg::CONTACT_NONE;
    end else if (nr_n == '0 || nr_n == den_n || ns_n == '0 || ns_n == den_n) begin
      // r or s exactly at an end of its segment
      contact_nxt = scc_pkg::CONTACT_TOUCH;
    end else begin
      contact_nxt = scc_pkg::CONTACT_CROSS;
    end
  end

  // Result register: hold while the consumer stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= prod_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && prod_valid_r) begin
      contact_r <= contact_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = scc_pkg::OutDataW'(contact_r);

endmodule

>>> bench/scc_contact_monitor.sv
`timescale 1ns / 100ps
// Watches both streams of segment_contact_classifier, predicts each contact code and checks it.
// Depends on scc_pkg for the coordinate packing, the arithmetic widths and the contact codes.
module scc_contact_monitor
  import scc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OutDataW-1:0] out_tdata,
  output int                  mismatches,
  output int                  contacts_pending,
  output int                  pairs_apart,
  output int                  pairs_crossing,
  output int                  pairs_touching
);

  contact_t expected_contacts[$];

  function automatic sum_t wide_mul(input diff_t a, input diff_t b);
    sum_t wa;
    sum_t wb;
    wa = a;
    wb = b;
    return wa * wb;
  endfunction

  // Exact contact test: r = nr/den and s = ns/den against [0,1] without division,
  // collinear pairs by projecting C and D onto AB against its squared length.
  function automatic contact_t classify_contact(input logic [InDataW-1:0] word);
    coord_t ax, ay, bx, by, cx, cy, dx, dy;
    diff_t  abx, aby, cdx, cdy, cax, cay, acx, acy, adx, ady;
    sum_t   nr, ns, den, len, pc, pd;
    ax = word[IdxAx*CoordW +: CoordW];
    ay = word[IdxAy*CoordW +: CoordW];
    bx = word[IdxBx*CoordW +: CoordW];
    by = word[IdxBy*CoordW +: CoordW];
    cx = word[IdxCx*CoordW +: CoordW];
    cy = word[IdxCy*CoordW +: CoordW];
    dx = word[IdxDx*CoordW +: CoordW];
    dy = word[IdxDy*CoordW +: CoordW];
    abx = bx - ax;
    aby = by - ay;
    cdx = dx - cx;
    cdy = dy - cy;
    cax = ax - cx;
    cay = ay - cy;
    acx = cx - ax;
    acy = cy - ay;
    adx = dx - ax;
    ady = dy - ay;
    nr  = wide_mul(cay, cdx) - wide_mul(cax, cdy);
    ns  = wide_mul(cay, abx) - wide_mul(cax, aby);
    den = wide_mul(abx, cdy) - wide_mul(aby, cdx);
    if (den == 0) begin
      if (nr != 0) return CONTACT_NONE;
      len = wide_mul(abx, abx) + wide_mul(aby, aby);
      pc  = wide_mul(acx, abx) + wide_mul(acy, aby);
      pd  = wide_mul(adx, abx) + wide_mul(ady, aby);
      if ((pc > len && pd > len) || (pc < 0 && pd < 0)) return CONTACT_NONE;
      if (pc == len || pd == len || pc == 0 || pd == 0) return CONTACT_TOUCH;
      return CONTACT_CROSS;
    end
    if (den < 0) begin
      den = -den;
      nr  = -nr;
      ns  = -ns;
    end
    if (nr < 0 || nr > den || ns < 0 || ns > den) return CONTACT_NONE;
    if (nr == 0 || nr == den || ns == 0 || ns == den) return CONTACT_TOUCH;
    return CONTACT_CROSS;
  endfunction

  always @(posedge clk) begin
    logic [ContactW-1:0] got;
    contact_t            want;
    if (!rst_n) begin
      expected_contacts.delete();
      mismatches     = 0;
      pairs_apart    = 0;
      pairs_crossing = 0;
      pairs_touching = 0;
    end else begin
      // Retire first, so a request taken on this edge never meets its own result
      if (out_tvalid && out_tready) begin
        got = out_tdata[ContactW-1:0];
        if (expected_contacts.size() == 0) begin
          mismatches++;
          $error("contact: expected nothing outstanding, got %0d", got);
        end else begin
          want = expected_contacts.pop_front();
          if (got !== want) begin
            mismatches++;
            $error("contact: expected %0d, got %0d", want, got);
          end
          case (want)
            CONTACT_NONE:  pairs_apart++;
            CONTACT_CROSS: pairs_crossing++;
            CONTACT_TOUCH: pairs_touching++;
            default: ;
          endcase
        end
      end
      if (in_tvalid && in_tready) expected_contacts.push_back(classify_contact(in_tdata));
    end
    contacts_pending = expected_contacts.size();
  end

endmodule

>>> bench/tb_segment_contact_classifier.sv
`timescale 1ns / 100ps
// Top of the segment contact classifier bench: clock, reset, request stimulus and verdict.
// Depends on scc_pkg, segment_contact_classifier and scc_contact_monitor.
module tb_segment_contact_classifier;
  import scc_pkg::*;

  // Generous bound on the whole run, in cycles, for the watchdog
  localparam int CycleLimit   = 200000;
  localparam int PhaseItems   = 175;
  localparam int NumPhases    = 4;
  // Cycles to hold after the last result so a stray extra result still shows up
  localparam int SettleCycles = 8;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  // ax, ay, bx, by, cx, cy, dx, dy, CoordW bits each, lowest bits first
  logic [InDataW-1:0]  in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // contact in the low ContactW bits, zero padded
  logic [OutDataW-1:0] out_tdata;

  int mismatches;
  int contacts_pending;
  int pairs_apart;
  int pairs_crossing;
  int pairs_touching;
  int requests_taken = 0;

  // Percent chance per cycle that the sender idles or the receiver stalls
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  segment_contact_classifier i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  scc_contact_monitor i_monitor (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .mismatches       (mismatches),
    .contacts_pending (contacts_pending),
    .pairs_apart      (pairs_apart),
    .pairs_crossing   (pairs_crossing),
    .pairs_touching   (pairs_touching)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Count accepted requests at the rising edge; the driver polls this at the falling edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) requests_taken <= requests_taken + 1;
  end

  // Receiver back-pressure: redraw tready every cycle at the current stall rate
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: give up if the run hangs anywhere
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // Offer one segment pair, idling first at the sender rate, and hold it until taken.
  // Returns at the falling edge after acceptance with tvalid still high.
  task automatic send_pair(input int ax, input int ay, input int bx, input int by,
                           input int cx, input int cy, input int dx, input int dy);
    logic [InDataW-1:0] word;
    int                 target;
    word = '0;
    word[IdxAx*CoordW +: CoordW] = coord_t'(ax);
    word[IdxAy*CoordW +: CoordW] = coord_t'(ay);
    word[IdxBx*CoordW +: CoordW] = coord_t'(bx);
    word[IdxBy*CoordW +: CoordW] = coord_t'(by);
    word[IdxCx*CoordW +: CoordW] = coord_t'(cx);
    word[IdxCy*CoordW +: CoordW] = coord_t'(cy);
    word[IdxDx*CoordW +: CoordW] = coord_t'(dx);
    word[IdxDy*CoordW +: CoordW] = coord_t'(dy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    target = requests_taken + 1;
    do @(negedge clk); while (requests_taken < target);
  endtask

  // Drop tvalid and hold off until every outstanding contact has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (contacts_pending != 0) @(negedge clk);
  endtask

  // One random pair. Most are built to land on the interesting geometry:
  // lattice boxes, collinear runs, shared endpoints, extremes and point segments.
  task automatic send_random();
    int p[8];
    int pick, sel, base_x, base_y, ux, uy, k, m, n;
    pick   = $urandom_range(99);
    base_x = $urandom_range(60000) - 30000;
    base_y = $urandom_range(60000) - 30000;
    ux     = $urandom_range(8) - 4;
    uy     = $urandom_range(8) - 4;
    for (int i = 0; i < NumCoord; i += 2) begin
      p[i]     = base_x + $urandom_range(12) - 6;
      p[i + 1] = base_y + $urandom_range(12) - 6;
    end
    if (pick < 20) begin
      // noise over the whole coordinate range
      for (int i = 0; i < NumCoord; i++) p[i] = $urandom_range(65535) - 32768;
    end else if (pick < 45) begin
      // small box at a random place: crossings and near misses are frequent
    end else if (pick < 65) begin
      // all four points on one lattice line: overlap, end touch or apart
      k = $urandom_range(9) - 3;
      m = $urandom_range(9) - 3;
      n = $urandom_range(9) - 3;
      p[IdxBx] = p[IdxAx] + k * ux;
      p[IdxBy] = p[IdxAy] + k * uy;
      p[IdxCx] = p[IdxAx] + m * ux;
      p[IdxCy] = p[IdxAy] + m * uy;
      p[IdxDx] = p[IdxAx] + n * ux;
      p[IdxDy] = p[IdxAy] + n * uy;
    end else if (pick < 80) begin
      // C sits on A, on B or on the lattice point midway along AB
      sel = $urandom_range(2);
      p[IdxBx] = p[IdxAx] + 2 * ux;
      p[IdxBy] = p[IdxAy] + 2 * uy;
      p[IdxCx] = p[IdxAx] + sel * ux;
      p[IdxCy] = p[IdxAy] + sel * uy;
    end else if (pick < 90) begin
      for (int i = 0; i < NumCoord; i++) begin
        case ($urandom_range(6))
          0: p[i] = -32768;
          1: p[i] = -32767;
          2: p[i] = -1;
          3: p[i] = 0;
          4: p[i] = 1;
          5: p[i] = 32766;
          default: p[i] = 32767;
        endcase
      end
    end else begin
      // point given as a segment, on either side or both
      sel = $urandom_range(2);
      if (sel != 1) begin
        p[IdxBx] = p[IdxAx];
        p[IdxBy] = p[IdxAy];
      end
      if (sel != 0) begin
        p[IdxDx] = p[IdxCx];
        p[IdxDy] = p[IdxCy];
      end
    end
    send_pair(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed pairs at full rate
    send_pair(0, 0, 4, 4, 0, 4, 4, 0);          // plain crossing
    send_pair(0, 4, 4, 0, 0, 0, 4, 4);          // same, positive denominator
    send_pair(0, 0, 4, 0, 2, 0, 2, 4);          // T junction, C on AB
    send_pair(0, 0, 2, 2, 0, 4, 4, 0);          // B lands inside CD
    send_pair(0, 0, 1, 1, 0, 3, 3, 0);          // lines cross beyond the end of AB
    send_pair(0, 0, 1, 1, 5, 0, 6, -3);         // far apart, not parallel
    send_pair(0, 0, 4, 0, 0, 1, 4, 1);          // parallel, offset
    send_pair(0, 0, 4, 0, 2, 0, 6, 0);          // collinear overlap
    send_pair(0, 0, 4, 0, 4, 0, 8, 0);          // collinear, end to end
    send_pair(0, 0, 4, 0, 6, 0, 8, 0);          // collinear, gap ahead
    send_pair(0, 0, 4, 0, -6, 0, -2, 0);        // collinear, gap behind
    send_pair(0, 0, 4, 0, -2, 0, 6, 0);         // collinear, CD covers AB
    send_pair(0, 0, 4, 4, 2, 2, 2, 2);          // point inside AB
    send_pair(0, 0, 4, 4, 2, 3, 2, 3);          // point off AB
    send_pair(5, 5, 5, 5, 5, 5, 5, 5);          // everything one point
    send_pair(3, 3, 3, 3, 0, 0, 6, 6);          // point AB inside CD
    send_pair(1, 1, 5, 2, 1, 1, -3, 4);         // shared start, not collinear
    send_pair(1, 1, 5, 2, -3, 4, 5, 2);         // shared end
    send_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send_pair(-32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768);
    send_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_pair(-32768, 32767, 32767, -32768, -32768, -32768, 32767, -32767);
    drain_results();

    // Random phases: full rate, idle sender, stalling receiver, both
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 87;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 87;
        end
        default: begin
          send_idle_pct  = 32;
          recv_stall_pct = 32;
        end
      endcase
      repeat (PhaseItems) send_random();
      drain_results();
    end

    repeat (SettleCycles) @(negedge clk);
    $display("Checked %0d segment pairs under four handshake mixes.", requests_taken);
    $display("Contacts seen: %0d apart, %0d crossing or overlapping, %0d touching.",
             pairs_apart, pairs_crossing, pairs_touching);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
